// ===== rtl/svp_pkg.sv =====
// svp_pkg: shared types, constants and the control store of the sound variation picker.
// Holds the microcode table read by sound_variation_picker; no dependencies.
`default_nettype none

package svp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ID_BITS     = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int FIELD_W     = 16;
    localparam int DIV_CNT_W   = $clog2(FIELD_W + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int PC_W        = 5;

    // request codes
    localparam logic [1:0] REQ_SELECT     = 2'd0;
    localparam logic [1:0] REQ_ADD_UPDATE = 2'd1;
    localparam logic [1:0] REQ_ADD_ABSENT = 2'd2;
    localparam logic [1:0] REQ_REMOVE     = 2'd3;

    // result status codes
    localparam logic [2:0] ST_PRESENT   = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_SELECTED  = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE    = 2'd1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PTR_CLR,
        OP_READ_PTR,
        OP_INC_NOMATCH,
        OP_INC_PTR,
        OP_WR_VOL,
        OP_APPEND,
        OP_WR_BACK_INC,
        OP_DEC_COUNT,
        OP_DIV_LD_DRAW,
        OP_DIV_LD_LP,
        OP_DIV_STEP,
        OP_LP_FROM_REM,
        OP_READ_LP
    } op_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_PTR_END,
        C_NOMATCH,
        C_FULL,
        C_EMPTY,
        C_SEQ,
        C_DIV_MORE,
        C_REM_NE_LP
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic            emit;
        logic [2:0]      st;
        logic [PC_W-1:0] target;
    } uword_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_UA_CLR   = 5'd1;
    localparam logic [PC_W-1:0] PC_UA_RD    = 5'd2;
    localparam logic [PC_W-1:0] PC_UA_CMP   = 5'd3;
    localparam logic [PC_W-1:0] PC_UA_HIT   = 5'd4;
    localparam logic [PC_W-1:0] PC_AA_CLR   = 5'd5;
    localparam logic [PC_W-1:0] PC_AA_RD    = 5'd6;
    localparam logic [PC_W-1:0] PC_AA_CMP   = 5'd7;
    localparam logic [PC_W-1:0] PC_AA_HIT   = 5'd8;
    localparam logic [PC_W-1:0] PC_ADD_NF   = 5'd9;
    localparam logic [PC_W-1:0] PC_ADD_APP  = 5'd10;
    localparam logic [PC_W-1:0] PC_ADD_FULL = 5'd11;
    localparam logic [PC_W-1:0] PC_RM_CLR   = 5'd12;
    localparam logic [PC_W-1:0] PC_RM_RD    = 5'd13;
    localparam logic [PC_W-1:0] PC_RM_CMP   = 5'd14;
    localparam logic [PC_W-1:0] PC_RM_NXT   = 5'd15;
    localparam logic [PC_W-1:0] PC_RM_SHRD  = 5'd16;
    localparam logic [PC_W-1:0] PC_RM_SHWR  = 5'd17;
    localparam logic [PC_W-1:0] PC_RM_DONE  = 5'd18;
    localparam logic [PC_W-1:0] PC_RM_NF    = 5'd19;
    localparam logic [PC_W-1:0] PC_SL_CHK   = 5'd20;
    localparam logic [PC_W-1:0] PC_SL_MODE  = 5'd21;
    localparam logic [PC_W-1:0] PC_SL_RDIV  = 5'd22;
    localparam logic [PC_W-1:0] PC_SL_RCHK  = 5'd23;
    localparam logic [PC_W-1:0] PC_SL_SEQ   = 5'd24;
    localparam logic [PC_W-1:0] PC_SL_SDIV  = 5'd25;
    localparam logic [PC_W-1:0] PC_SL_SSET  = 5'd26;
    localparam logic [PC_W-1:0] PC_SL_READ  = 5'd27;
    localparam logic [PC_W-1:0] PC_SL_OUT   = 5'd28;
    localparam logic [PC_W-1:0] PC_SL_EMPTY = 5'd29;

    function automatic uword_t mk(op_t op, cond_t cond, logic emit, logic [2:0] st,
                                  logic [PC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.cond   = cond;
        w.emit   = emit;
        w.st     = st;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            // add or update
            PC_UA_CLR:   w = mk(OP_PTR_CLR,     C_NONE,     1'b0, ST_PRESENT,   PC_IDLE);
            PC_UA_RD:    w = mk(OP_READ_PTR,    C_PTR_END,  1'b0, ST_PRESENT,   PC_ADD_NF);
            PC_UA_CMP:   w = mk(OP_INC_NOMATCH, C_NOMATCH,  1'b0, ST_PRESENT,   PC_UA_RD);
            PC_UA_HIT:   w = mk(OP_WR_VOL,      C_ALWAYS,   1'b1, ST_PRESENT,   PC_IDLE);
            // add if absent
            PC_AA_CLR:   w = mk(OP_PTR_CLR,     C_NONE,     1'b0, ST_PRESENT,   PC_IDLE);
            PC_AA_RD:    w = mk(OP_READ_PTR,    C_PTR_END,  1'b0, ST_PRESENT,   PC_ADD_NF);
            PC_AA_CMP:   w = mk(OP_INC_NOMATCH, C_NOMATCH,  1'b0, ST_PRESENT,   PC_AA_RD);
            PC_AA_HIT:   w = mk(OP_NOP,         C_ALWAYS,   1'b1, ST_PRESENT,   PC_IDLE);
            // shared append tail
            PC_ADD_NF:   w = mk(OP_NOP,         C_FULL,     1'b0, ST_PRESENT,   PC_ADD_FULL);
            PC_ADD_APP:  w = mk(OP_APPEND,      C_ALWAYS,   1'b1, ST_ADDED,     PC_IDLE);
            PC_ADD_FULL: w = mk(OP_NOP,         C_ALWAYS,   1'b1, ST_FULL,      PC_IDLE);
            // remove with compaction
            PC_RM_CLR:   w = mk(OP_PTR_CLR,     C_NONE,     1'b0, ST_PRESENT,   PC_IDLE);
            PC_RM_RD:    w = mk(OP_READ_PTR,    C_PTR_END,  1'b0, ST_PRESENT,   PC_RM_NF);
            PC_RM_CMP:   w = mk(OP_INC_NOMATCH, C_NOMATCH,  1'b0, ST_PRESENT,   PC_RM_RD);
            PC_RM_NXT:   w = mk(OP_INC_PTR,     C_NONE,     1'b0, ST_PRESENT,   PC_IDLE);
            PC_RM_SHRD:  w = mk(OP_READ_PTR,    C_PTR_END,  1'b0, ST_PRESENT,   PC_RM_DONE);
            PC_RM_SHWR:  w = mk(OP_WR_BACK_INC, C_ALWAYS,   1'b0, ST_PRESENT,   PC_RM_SHRD);
            PC_RM_DONE:  w = mk(OP_DEC_COUNT,   C_ALWAYS,   1'b1, ST_REMOVED,   PC_IDLE);
            PC_RM_NF:    w = mk(OP_NOP,         C_ALWAYS,   1'b1, ST_NOT_FOUND, PC_IDLE);
            // select
            PC_SL_CHK:   w = mk(OP_NOP,         C_EMPTY,    1'b0, ST_PRESENT,   PC_SL_EMPTY);
            PC_SL_MODE:  w = mk(OP_DIV_LD_DRAW, C_SEQ,      1'b0, ST_PRESENT,   PC_SL_SEQ);
            PC_SL_RDIV:  w = mk(OP_DIV_STEP,    C_DIV_MORE, 1'b0, ST_PRESENT,   PC_SL_RDIV);
            PC_SL_RCHK:  w = mk(OP_LP_FROM_REM, C_REM_NE_LP, 1'b0, ST_PRESENT,  PC_SL_READ);
            PC_SL_SEQ:   w = mk(OP_DIV_LD_LP,   C_NONE,     1'b0, ST_PRESENT,   PC_IDLE);
            PC_SL_SDIV:  w = mk(OP_DIV_STEP,    C_DIV_MORE, 1'b0, ST_PRESENT,   PC_SL_SDIV);
            PC_SL_SSET:  w = mk(OP_LP_FROM_REM, C_NONE,     1'b0, ST_PRESENT,   PC_IDLE);
            PC_SL_READ:  w = mk(OP_READ_LP,     C_NONE,     1'b0, ST_PRESENT,   PC_IDLE);
            PC_SL_OUT:   w = mk(OP_NOP,         C_ALWAYS,   1'b1, ST_SELECTED,  PC_IDLE);
            PC_SL_EMPTY: w = mk(OP_NOP,         C_ALWAYS,   1'b1, ST_EMPTY,     PC_IDLE);
            default:     w = mk(OP_NOP,         C_ALWAYS,   1'b0, ST_PRESENT,   PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sound_variation_picker.sv =====
// Select in random mode runs a 16-step remainder of the draw and one more 5-step remainder
// when that lands on the last pick; round robin runs only the 5-step one; an empty table
// gives ST_EMPTY without a division. Add and remove scan from index 0 to a hit or the end.
// Remove then shifts the later entries down by one slot.
// One item at a time: start is taken again in the cycle done is high; the receiver
// cannot stall. Reset clears count, last pick, mode and loop flag; table contents stay.
`default_nettype none

module sound_variation_picker
    import svp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           req_type,
    input  wire logic [FIELD_W-1:0]   sound_id,
    input  wire logic [FIELD_W-1:0]   volume,
    input  wire logic [FIELD_W-1:0]   random_draw,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic                 cfg_data,
    output logic                      done,
    output logic [2:0]                status,
    output logic [FIELD_W-1:0]        sel_id,
    output logic [FIELD_W-1:0]        sel_volume,
    output logic                      sel_loop
);

    logic [PC_W-1:0]      pc_reg, pc_next;
    uword_t               uw;
    logic [CNT_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     lp_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [FIELD_W-1:0]   dvd_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [FIELD_W-1:0]   vol_reg;
    logic [FIELD_W-1:0]   draw_reg;
    logic                 mode_reg, loop_reg;
    logic [ID_BITS-1:0]   rd_id_reg;
    logic [FIELD_W-1:0]   rd_vol_reg;
    logic                 done_reg, sel_loop_reg;
    logic [2:0]           status_reg;
    logic [FIELD_W-1:0]   sel_id_reg, sel_volume_reg;

    logic [ID_BITS-1:0]   id_mem [MAX_ENTRIES];
    logic [FIELD_W-1:0]   vol_mem [MAX_ENTRIES];

    logic                 accept, take;
    logic [CNT_W:0]       div_sh;
    logic [CNT_W-1:0]     div_rem;
    logic [CNT_W-1:0]     lp_inc;
    logic [CNT_W-1:0]     ptr_dec;
    logic                 id_match;
    logic                 id_we, vol_we, rd_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [ID_BITS-1:0]   wr_id;
    logic [FIELD_W-1:0]   wr_vol;

    assign uw     = ucode(pc_reg);
    assign busy   = (pc_reg != PC_IDLE);
    assign accept = start && !busy;

    // one restoring remainder step per cycle
    assign div_sh  = {rem_reg, dvd_reg[FIELD_W-1]};
    assign div_rem = (div_sh >= {1'b0, count_reg}) ? CNT_W'(div_sh - {1'b0, count_reg})
                                                   : div_sh[CNT_W-1:0];
    assign lp_inc   = CNT_W'(lp_reg) + CNT_W'(1);
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign id_match = (rd_id_reg == id_reg);

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:    take = 1'b1;
            C_PTR_END:   take = (ptr_reg >= count_reg);
            C_NOMATCH:   take = !id_match;
            C_FULL:      take = (count_reg == CNT_W'(MAX_ENTRIES));
            C_EMPTY:     take = (count_reg == '0);
            C_SEQ:       take = mode_reg;
            C_DIV_MORE:  take = (dcnt_reg != DIV_CNT_W'(1));
            C_REM_NE_LP: take = (rem_reg != CNT_W'(lp_reg));
            default:     take = 1'b0;
        endcase

        if (!busy)
        begin
            pc_next = PC_IDLE;
            if (start)
            begin
                case (req_type)
                    REQ_SELECT:     pc_next = PC_SL_CHK;
                    REQ_ADD_UPDATE: pc_next = PC_UA_CLR;
                    REQ_ADD_ABSENT: pc_next = PC_AA_CLR;
                    REQ_REMOVE:     pc_next = PC_RM_CLR;
                    default:        pc_next = PC_IDLE;
                endcase
            end
        end
        else if (take)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    // table port control
    always_comb
    begin
        id_we   = 1'b0;
        vol_we  = 1'b0;
        rd_en   = 1'b0;
        wr_addr = ptr_reg[IDX_W-1:0];
        rd_addr = ptr_reg[IDX_W-1:0];
        wr_id   = id_reg;
        wr_vol  = vol_reg;
        case (uw.op)
            OP_READ_PTR:
            begin
                rd_en = 1'b1;
            end
            OP_READ_LP:
            begin
                rd_en   = 1'b1;
                rd_addr = lp_reg;
            end
            OP_WR_VOL:
            begin
                vol_we = 1'b1;
            end
            OP_APPEND:
            begin
                id_we   = 1'b1;
                vol_we  = 1'b1;
                wr_addr = count_reg[IDX_W-1:0];
            end
            OP_WR_BACK_INC:
            begin
                id_we   = 1'b1;
                vol_we  = 1'b1;
                wr_addr = ptr_dec[IDX_W-1:0];
                wr_id   = rd_id_reg;
                wr_vol  = rd_vol_reg;
            end
            default:
            begin
                id_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (vol_we)
        begin
            vol_mem[wr_addr] <= wr_vol;
        end
        if (rd_en)
        begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_vol_reg <= vol_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= PC_IDLE;
            count_reg <= '0;
            lp_reg    <= '0;
            mode_reg  <= 1'b0;
            loop_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            done_reg <= busy && uw.emit;
            if (cfg_we && (cfg_index == CFG_SELECTION_MODE))
            begin
                mode_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_LOOP_ENABLE))
            begin
                loop_reg <= cfg_data;
            end
            case (uw.op)
                OP_APPEND:      count_reg <= count_reg + CNT_W'(1);
                OP_DEC_COUNT:   count_reg <= count_reg - CNT_W'(1);
                OP_LP_FROM_REM: lp_reg    <= rem_reg[IDX_W-1:0];
                default:        lp_reg    <= lp_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg   <= sound_id[ID_BITS-1:0];
            vol_reg  <= volume;
            draw_reg <= random_draw;
        end
        case (uw.op)
            OP_PTR_CLR:     ptr_reg <= '0;
            OP_INC_PTR:     ptr_reg <= ptr_reg + CNT_W'(1);
            OP_WR_BACK_INC: ptr_reg <= ptr_reg + CNT_W'(1);
            OP_INC_NOMATCH:
            begin
                if (!id_match)
                begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
            end
            OP_DIV_LD_DRAW:
            begin
                rem_reg  <= '0;
                dvd_reg  <= draw_reg;
                dcnt_reg <= DIV_CNT_W'(FIELD_W);
            end
            OP_DIV_LD_LP:
            begin
                // lp+1 sits in the top bits, only CNT_W steps are run
                rem_reg  <= '0;
                dvd_reg  <= {lp_inc, {(FIELD_W - CNT_W){1'b0}}};
                dcnt_reg <= DIV_CNT_W'(CNT_W);
            end
            OP_DIV_STEP:
            begin
                rem_reg  <= div_rem;
                dvd_reg  <= {dvd_reg[FIELD_W-2:0], 1'b0};
                dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
        if (busy && uw.emit)
        begin
            status_reg <= uw.st;
            if (uw.st == ST_SELECTED)
            begin
                sel_id_reg     <= FIELD_W'(rd_id_reg);
                sel_volume_reg <= rd_vol_reg;
                sel_loop_reg   <= loop_reg;
            end
            else
            begin
                sel_id_reg     <= '0;
                sel_volume_reg <= '0;
                sel_loop_reg   <= 1'b0;
            end
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign sel_id     = sel_id_reg;
    assign sel_volume = sel_volume_reg;
    assign sel_loop   = sel_loop_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while program still running");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not start a program");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_ADDED)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("added item without count increment");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_REMOVED)) |->
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removed item without count decrement");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sound_variation_checker.sv =====
// sound_variation_checker: watches the request, config and result channels of
// sound_variation_picker, keeps its own copy of the sound table and checks every result.
// Depends on svp_pkg for widths, request, status and register codes.
`default_nettype none

module sound_variation_checker
    import svp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [FIELD_W-1:0]   sound_id,
    input  logic [FIELD_W-1:0]   volume,
    input  logic [FIELD_W-1:0]   random_draw,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  logic                 done,
    input  logic [2:0]           status,
    input  logic [FIELD_W-1:0]   sel_id,
    input  logic [FIELD_W-1:0]   sel_volume,
    input  logic                 sel_loop,
    output int                   failures,
    output int                   outstanding
);

    typedef struct packed {
        logic [2:0]         status;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] vol;
        logic               loop_flag;
    } pick_result_t;

    pick_result_t       pending_picks[$];
    pick_result_t       want;
    logic [FIELD_W-1:0] tbl_id [MAX_ENTRIES];
    logic [FIELD_W-1:0] tbl_vol[MAX_ENTRIES];
    int                 tbl_count;
    int                 last_idx;
    logic               mode_seq;
    logic               loop_on;

    // first slot holding this id, or tbl_count when absent
    function automatic int find_slot(input logic [FIELD_W-1:0] id);
        int k;
        for (k = 0; k < tbl_count; k++)
        begin
            if (tbl_id[k] == id)
                return k;
        end
        return tbl_count;
    endfunction

    // applies one request to the table copy and returns the result it should give
    function automatic pick_result_t apply_request(input logic [1:0] req,
                                                   input logic [FIELD_W-1:0] id,
                                                   input logic [FIELD_W-1:0] vol,
                                                   input logic [FIELD_W-1:0] draw);
        pick_result_t r;
        int           pos;
        int           k;
        int           cand;
        r = '0;
        case (req)
            REQ_SELECT:
            begin
                if (tbl_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    if (!mode_seq)
                    begin
                        cand = int'(draw) % tbl_count;
                        // a repeat of the last pick steps on by one
                        if (cand != last_idx)
                            last_idx = cand;
                        else
                            last_idx = (last_idx + 1) % tbl_count;
                    end
                    else
                    begin
                        last_idx = (last_idx + 1) % tbl_count;
                    end
                    r.status    = ST_SELECTED;
                    r.id        = tbl_id[last_idx % MAX_ENTRIES];
                    r.vol       = tbl_vol[last_idx % MAX_ENTRIES];
                    r.loop_flag = loop_on;
                end
            end
            REQ_ADD_UPDATE, REQ_ADD_ABSENT:
            begin
                pos = find_slot(id);
                if (pos < tbl_count)
                begin
                    if (req == REQ_ADD_UPDATE)
                        tbl_vol[pos] = vol;
                    r.status = ST_PRESENT;
                end
                else if (tbl_count >= MAX_ENTRIES)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    tbl_id[tbl_count]  = id;
                    tbl_vol[tbl_count] = vol;
                    tbl_count++;
                    r.status = ST_ADDED;
                end
            end
            default:
            begin
                pos = find_slot(id);
                if (pos >= tbl_count)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    // close the gap; last_idx may now be stale, the modulo fixes it
                    for (k = pos; k + 1 < tbl_count; k++)
                    begin
                        tbl_id[k]  = tbl_id[k + 1];
                        tbl_vol[k] = tbl_vol[k + 1];
                    end
                    tbl_count--;
                    r.status = ST_REMOVED;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_count = 0;
            last_idx  = 0;
            mode_seq  = 1'b0;
            loop_on   = 1'b0;
            failures  = 0;
            pending_picks.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_picks.size() == 0)
                begin
                    $error("result with no request waiting: status %0d", status);
                    failures++;
                end
                else
                begin
                    want = pending_picks.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failures++;
                    end
                    if (sel_id !== want.id)
                    begin
                        $error("sel_id: expected %h, got %h", want.id, sel_id);
                        failures++;
                    end
                    if (sel_volume !== want.vol)
                    begin
                        $error("sel_volume: expected %h, got %h", want.vol, sel_volume);
                        failures++;
                    end
                    if (sel_loop !== want.loop_flag)
                    begin
                        $error("sel_loop: expected %0d, got %0d", want.loop_flag, sel_loop);
                        failures++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SELECTION_MODE: mode_seq = cfg_data;
                    CFG_LOOP_ENABLE:    loop_on  = cfg_data;
                    default:            ;
                endcase
            end
            if (start && !busy)
                pending_picks = {pending_picks,
                                 apply_request(req_type, sound_id, volume, random_draw)};
            outstanding <= pending_picks.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: drives requests and register writes into sound_variation_picker and
// gives the verdict; result checking lives in sound_variation_checker. Depends on svp_pkg.
`default_nettype none

module testbench;
    import svp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE   = 24;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 165;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [1:0]           req_type    = REQ_SELECT;
    logic [FIELD_W-1:0]   sound_id    = '0;
    logic [FIELD_W-1:0]   volume      = '0;
    logic [FIELD_W-1:0]   random_draw = '0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_SELECTION_MODE;
    logic                 cfg_data    = 1'b0;
    logic                 done;
    logic [2:0]           status;
    logic [FIELD_W-1:0]   sel_id;
    logic [FIELD_W-1:0]   sel_volume;
    logic                 sel_loop;
    int                   failures;
    int                   outstanding;
    int                   cycle_count = 0;
    logic [FIELD_W-1:0]   id_pool[POOL_SIZE];

    always #2 clk = ~clk;

    sound_variation_picker i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .sound_id    (sound_id),
        .volume      (volume),
        .random_draw (random_draw),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .sel_id      (sel_id),
        .sel_volume  (sel_volume),
        .sel_loop    (sel_loop)
    );

    sound_variation_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .sound_id    (sound_id),
        .volume      (volume),
        .random_draw (random_draw),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .sel_id      (sel_id),
        .sel_volume  (sel_volume),
        .sel_loop    (sel_loop),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL sound_variation_picker");
            $finish;
        end
    end

    // hold start low until every issued request has its result
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic rest_after_item();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            wait_drained();
        end
        else
        begin
            if (r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 80);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // returns once the item is taken, then idles for a random while
    task automatic issue_request(input logic [1:0] req, input logic [FIELD_W-1:0] id,
                                 input logic [FIELD_W-1:0] vol,
                                 input logic [FIELD_W-1:0] draw);
        start       <= 1'b1;
        req_type    <= req;
        sound_id    <= id;
        volume      <= vol;
        random_draw <= draw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rest_after_item();
    endtask

    function automatic logic [FIELD_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 8)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return FIELD_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // alternate fill-heavy and drain-heavy stretches so the table swings between full and empty
    task automatic run_random(input int n);
        int         k;
        int         pick;
        int         span;
        logic       filling;
        logic [1:0] req;
        filling = 1'b1;
        span    = $urandom_range(20, 80);
        for (k = 0; k < n; k++)
        begin
            if (span == 0)
            begin
                filling = !filling;
                span    = $urandom_range(20, 80);
            end
            span--;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                req = REQ_SELECT;
            else if (pick < (filling ? 55 : 45))
                req = REQ_ADD_UPDATE;
            else if (pick < (filling ? 80 : 55))
                req = REQ_ADD_ABSENT;
            else
                req = REQ_REMOVE;
            issue_request(req, pick_id(), FIELD_W'($urandom_range(0, 16'hFFFF)),
                          FIELD_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    initial
    begin
        int k;
        int ph;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (k = 2; k < POOL_SIZE; k++)
            id_pool[k] = FIELD_W'($urandom_range(0, 16'hFFFF));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset config, random mode with loop off
        issue_request(REQ_SELECT,     16'h0000, 16'h0000, 16'h0000);
        issue_request(REQ_REMOVE,     16'h1234, 16'h0000, 16'h0000);
        issue_request(REQ_ADD_UPDATE, 16'h0000, 16'hFFFF, 16'h0000);
        issue_request(REQ_ADD_ABSENT, 16'hFFFF, 16'h0000, 16'hFFFF);
        issue_request(REQ_ADD_ABSENT, 16'h0000, 16'h1234, 16'h0000);
        issue_request(REQ_ADD_UPDATE, 16'hFFFF, 16'hFFFF, 16'h0000);
        // draws that land on the last pick
        issue_request(REQ_SELECT,     16'h0000, 16'h0000, 16'h0000);
        issue_request(REQ_SELECT,     16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue_request(REQ_REMOVE,     16'h0000, 16'h0000, 16'h0000);
        issue_request(REQ_SELECT,     16'h0000, 16'h0000, 16'h5555);
        for (k = 1; k < MAX_ENTRIES; k++)
            issue_request(REQ_ADD_UPDATE, FIELD_W'(k), FIELD_W'($urandom_range(0, 16'hFFFF)),
                          16'h0000);
        // table full
        issue_request(REQ_ADD_ABSENT, 16'h8000, 16'h8000, 16'h0000);
        issue_request(REQ_ADD_UPDATE, 16'h8000, 16'h8000, 16'h0000);
        issue_request(REQ_ADD_UPDATE, 16'hFFFF, 16'h8000, 16'h0000);
        issue_request(REQ_SELECT,     16'h0000, 16'h0000, 16'hAAAA);
        issue_request(REQ_REMOVE,     16'h0007, 16'h0000, 16'h0000);
        issue_request(REQ_REMOVE,     16'h000F, 16'h0000, 16'h0000);
        issue_request(REQ_REMOVE,     16'hFFFF, 16'h0000, 16'h0000);
        issue_request(REQ_SELECT,     16'h0000, 16'h0000, 16'h000D);

        // phases: both flags on, then each one off, then both off, then random settings
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            write_reg(CFG_SPARE_2, 1'($urandom_range(0, 1)));
            write_reg(CFG_SPARE_3, 1'($urandom_range(0, 1)));
            write_reg(CFG_SELECTION_MODE, ph < 4 ? (ph % 2 == 0) : 1'($urandom_range(0, 1)));
            write_reg(CFG_LOOP_ENABLE,    ph < 4 ? (ph < 2)      : 1'($urandom_range(0, 1)));
            cfg_we <= 1'b0;
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("PASS sound_variation_picker");
        else
            $display("FAIL sound_variation_picker");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/svp_pkg.sv
rtl/sound_variation_picker.sv
tb/sv/sound_variation_checker.sv
tb/sv/testbench.sv
